### rtl/cbae_pkg.sv
`default_nettype none
package cbae_pkg;

  localparam int COORD_BITS    = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int EPS_BITS      = 16;
  localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(1);

  // Derivative coefficients a, b (signed), c (signed) and their magnitudes
  localparam int AW  = COORD_BITS + 5;
  localparam int CW  = COORD_BITS + 3;
  localparam int MGW = COORD_BITS + 4;
  // Square root: root width and discriminant width
  localparam int RW  = COORD_BITS + 5;
  localparam int DW  = 2 * RW;
  // Root numerator and denominator
  localparam int NW  = COORD_BITS + 7;
  localparam int MW  = COORD_BITS + 6;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t ctrl_start;
    coord_t ctrl_near_start;
    coord_t ctrl_near_end;
    coord_t ctrl_end;
    coord_t lo_in;
    coord_t hi_in;
  } curve_in_t;

  typedef struct packed {
    coord_t lo_out;
    coord_t hi_out;
  } extent_out_t;

  typedef struct packed {
    logic lin;
    logic blin;
    logic dneg;
  } mode_t;

  typedef struct packed {
    coord_t p0;
    coord_t p1;
    coord_t p2;
    coord_t p3;
    coord_t lo;
    coord_t hi;
  } pts_t;

  typedef struct packed {
    pts_t                  pts;
    logic signed [AW-1:0]  a;
    logic signed [AW-1:0]  b;
    logic signed [CW-1:0]  c;
    mode_t                 mode;
  } carry_t;

endpackage
`default_nettype wire

### rtl/cubic_bezier_axis_extent.sv
// Pipeline: front, square root, root division and evaluation, in that order; the square root
// stage chain, one root bit per stage, is its longest part.
// Throughput: one curve per cycle; busy is never raised, start is taken on every cycle.
// Results appear for exactly one cycle with done; the receiver cannot stall them.
// Reset (rst, synchronous, active high) drops every item in flight and sets epsilon to 1.
`default_nettype none
module cubic_bezier_axis_extent #(
  parameter int FRAC_BITS = cbae_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  cbae_pkg::curve_in_t             curve,
  input  logic                            cfg_wr_en,
  input  logic [cbae_pkg::EPS_BITS-1:0]   cfg_wr_data,
  output logic                            done,
  output cbae_pkg::extent_out_t           extent
);

  localparam int LAT = cbae_pkg::COORD_BITS + FRAC_BITS + 17;

  logic [cbae_pkg::EPS_BITS-1:0] epsilon;
  logic                          accept;

  logic                          f_valid;
  cbae_pkg::carry_t              f_carry;
  logic [cbae_pkg::DW-1:0]       f_disc;

  logic                          s_valid;
  cbae_pkg::carry_t              s_carry;
  logic [cbae_pkg::RW-1:0]       s_root;

  logic                          r_valid;
  cbae_pkg::pts_t                r_pts;
  logic [1:0]                    r_ok;
  logic [1:0][FRAC_BITS-1:0]     r_frac;

  // The pipeline never holds, so every start beat is taken
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Degeneracy threshold; the user must write it only while the pipeline is empty (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= cbae_pkg::EPS_RESET;
    end else if (cfg_wr_en) begin
      epsilon <= cfg_wr_data;
    end
  end

  // Coefficients, end point, discriminant (four stages)
  cbae_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .curve    (curve),
    .eps      (epsilon),
    .out_valid(f_valid),
    .carry    (f_carry),
    .disc     (f_disc)
  );

  // Integer square root of the discriminant, one bit per stage
  cbae_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .carry_in (f_carry),
    .disc     (f_disc),
    .out_valid(s_valid),
    .carry_out(s_carry),
    .root     (s_root)
  );

  // Root selection and fraction division, one quotient bit per stage
  cbae_root #(.FRAC_BITS(FRAC_BITS)) u_root (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_valid),
    .carry    (s_carry),
    .root     (s_root),
    .out_valid(r_valid),
    .pts      (r_pts),
    .ok       (r_ok),
    .frac     (r_frac)
  );

  // Curve value at each root and final extent merge
  cbae_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
    .clk      (clk),
    .rst      (rst),
    .in_valid (r_valid),
    .pts      (r_pts),
    .ok       (r_ok),
    .frac     (r_frac),
    .out_valid(done),
    .extent   (extent)
  );

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("done beat without a matching start");

  a_lo_covers_end: assert property (@(posedge clk) disable iff (rst)
    done |-> extent.lo_out <= $past(curve.ctrl_end, LAT))
    else $error("lower bound does not cover end point");

  a_hi_covers_end: assert property (@(posedge clk) disable iff (rst)
    done |-> extent.hi_out >= $past(curve.ctrl_end, LAT))
    else $error("upper bound does not cover end point");

  a_lo_not_raised: assert property (@(posedge clk) disable iff (rst)
    done |-> extent.lo_out <= $past(curve.lo_in, LAT))
    else $error("lower bound raised above input");

endmodule
`default_nettype wire

### rtl/cbae_front.sv
`default_nettype none
module cbae_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  cbae_pkg::curve_in_t             curve,
  input  logic [cbae_pkg::EPS_BITS-1:0]   eps,
  output logic                            out_valid,
  output cbae_pkg::carry_t                carry,
  output logic [cbae_pkg::DW-1:0]         disc
);

  localparam int AW  = cbae_pkg::AW;
  localparam int CW  = cbae_pkg::CW;
  localparam int MGW = cbae_pkg::MGW;
  localparam int DW  = cbae_pkg::DW;
  localparam int MCW = cbae_pkg::COORD_BITS + 2;
  localparam int L   = MGW / 2;
  localparam int HB  = MGW - L;
  localparam int HC  = MCW - L;

  logic signed [AW-1:0] e0, e1, e2, e3, a_c, b_c;
  logic signed [CW-1:0] c_c;
  cbae_pkg::coord_t     lo_c, hi_c;

  logic v1, v2, v3, v4;
  cbae_pkg::carry_t s1, s2, s3, s4;

  logic [AW-1:0]  aa, ab;
  logic [CW-1:0]  ac_m;
  logic [MGW-1:0] ma, mb;
  logic [MCW-1:0] mc;
  logic           lin_c, blin_c;

  logic [2*L-1:0]  bb_ll, ac_ll;
  logic [L+HB-1:0] bb_lh;
  logic [2*HB-1:0] bb_hh;
  logic [L+HC-1:0] ac_lh;
  logic [HB+L-1:0] ac_hl;
  logic [HB+HC-1:0] ac_hh;
  logic            sd2;

  logic [DW-1:0] bb_c, ac_c, bb3, ac4_3;
  logic          sd3;

  logic [DW-1:0] disc_c;
  logic          dneg_c;

  // Stage 1: derivative coefficients, end point into the extent
  always_comb begin
    e0  = AW'($signed(curve.ctrl_start));
    e1  = AW'($signed(curve.ctrl_near_start));
    e2  = AW'($signed(curve.ctrl_near_end));
    e3  = AW'($signed(curve.ctrl_end));
    a_c = AW'(3 * (e0 - e3)) + AW'(9 * (e2 - e1));
    b_c = AW'(6 * (e1 - (e2 <<< 1) + e3));
    c_c = CW'(3 * (e2 - e3));
    lo_c = (curve.ctrl_end < curve.lo_in) ? curve.ctrl_end : curve.lo_in;
    hi_c = (curve.ctrl_end > curve.hi_in) ? curve.ctrl_end : curve.hi_in;
  end

  // Stage 2: magnitudes, degeneracy tests, partial products
  always_comb begin
    aa     = s1.a[AW-1] ? $unsigned(-s1.a) : $unsigned(s1.a);
    ab     = s1.b[AW-1] ? $unsigned(-s1.b) : $unsigned(s1.b);
    ac_m   = s1.c[CW-1] ? $unsigned(-s1.c) : $unsigned(s1.c);
    ma     = aa[MGW-1:0];
    mb     = ab[MGW-1:0];
    mc     = ac_m[MCW-1:0];
    lin_c  = ma < MGW'(eps);
    blin_c = mb > MGW'(eps);
  end

  // Stage 3: sum partial products into b*b and 4*|a*c|
  always_comb begin
    bb_c = DW'(bb_ll) + (DW'(bb_lh) << (L + 1)) + (DW'(bb_hh) << (2 * L));
    ac_c = DW'(ac_ll) + ((DW'(ac_lh) + DW'(ac_hl)) << L) + (DW'(ac_hh) << (2 * L));
  end

  // Stage 4: discriminant, flag negative
  always_comb begin
    if (sd3) begin
      disc_c = bb3 + ac4_3;
      dneg_c = 1'b0;
    end else begin
      disc_c = bb3 - ac4_3;
      dneg_c = bb3 < ac4_3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    s1.pts.p0 <= curve.ctrl_start;
    s1.pts.p1 <= curve.ctrl_near_start;
    s1.pts.p2 <= curve.ctrl_near_end;
    s1.pts.p3 <= curve.ctrl_end;
    s1.pts.lo <= lo_c;
    s1.pts.hi <= hi_c;
    s1.a      <= a_c;
    s1.b      <= b_c;
    s1.c      <= c_c;
    s1.mode   <= '0;

    s2.pts       <= s1.pts;
    s2.a         <= s1.a;
    s2.b         <= s1.b;
    s2.c         <= s1.c;
    s2.mode.lin  <= lin_c;
    s2.mode.blin <= blin_c;
    s2.mode.dneg <= s1.mode.dneg;
    bb_ll <= mb[L-1:0] * mb[L-1:0];
    bb_lh <= mb[L-1:0] * mb[MGW-1:L];
    bb_hh <= mb[MGW-1:L] * mb[MGW-1:L];
    ac_ll <= ma[L-1:0] * mc[L-1:0];
    ac_lh <= ma[L-1:0] * mc[MCW-1:L];
    ac_hl <= ma[MGW-1:L] * mc[L-1:0];
    ac_hh <= ma[MGW-1:L] * mc[MCW-1:L];
    sd2   <= s1.a[AW-1] != s1.c[CW-1];

    s3    <= s2;
    bb3   <= bb_c;
    ac4_3 <= ac_c << 2;
    sd3   <= sd2;

    s4.pts       <= s3.pts;
    s4.a         <= s3.a;
    s4.b         <= s3.b;
    s4.c         <= s3.c;
    s4.mode.lin  <= s3.mode.lin;
    s4.mode.blin <= s3.mode.blin;
    s4.mode.dneg <= dneg_c;
    disc         <= disc_c;
  end

  assign out_valid = v4;
  assign carry     = s4;

endmodule
`default_nettype wire

### rtl/cbae_sqrt.sv
`default_nettype none
module cbae_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  cbae_pkg::carry_t          carry_in,
  input  logic [cbae_pkg::DW-1:0]   disc,
  output logic                      out_valid,
  output cbae_pkg::carry_t          carry_out,
  output logic [cbae_pkg::RW-1:0]   root
);

  localparam int RW = cbae_pkg::RW;
  localparam int DW = cbae_pkg::DW;

  logic             vld [RW+1];
  cbae_pkg::carry_t cq  [RW+1];
  logic [RW+1:0]    rem [RW+1];
  logic [RW-1:0]    rt  [RW+1];
  logic [DW-1:0]    dsh [RW+1];

  assign vld[0] = in_valid;
  assign cq[0]  = carry_in;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign dsh[0] = disc;

  // One root bit per stage: bring down two radicand bits, try 4r+1
  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic [RW+3:0] rem2, diff;
    logic          ge;

    always_comb begin
      rem2 = {rem[g], dsh[g][DW-1 -: 2]};
      diff = rem2 - (RW+4)'({rt[g], 2'b01});
      ge   = rem2 >= (RW+4)'({rt[g], 2'b01});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      cq[g+1]  <= cq[g];
      dsh[g+1] <= dsh[g] << 2;
      rem[g+1] <= ge ? diff[RW+1:0] : rem2[RW+1:0];
      rt[g+1]  <= {rt[g][RW-2:0], ge};
    end
  end

  assign out_valid = vld[RW];
  assign carry_out = cq[RW];
  assign root      = rt[RW];

endmodule
`default_nettype wire

### rtl/cbae_root.sv
`default_nettype none
module cbae_root #(
  parameter int FRAC_BITS = cbae_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  cbae_pkg::carry_t            carry,
  input  logic [cbae_pkg::RW-1:0]     root,
  output logic                        out_valid,
  output cbae_pkg::pts_t              pts,
  output logic [1:0]                  ok,
  output logic [1:0][FRAC_BITS-1:0]   frac
);

  localparam int NW  = cbae_pkg::NW;
  localparam int MUW = cbae_pkg::MW - 1;
  localparam int F   = FRAC_BITS;

  logic signed [NW-1:0] dn, bn, cn, an;
  logic signed [NW-1:0] n [2];
  logic signed [NW-1:0] m [2];
  logic [1:0]           en, ok_c;
  logic [NW-1:0]        un [2];
  logic [NW-1:0]        um [2];

  logic           vld  [F+1];
  cbae_pkg::pts_t pq   [F+1];
  logic [1:0]     okq  [F+1];
  logic [MUW-1:0] umq  [F+1][2];
  logic [MUW-1:0] rq   [F+1][2];
  logic [F-1:0]   accq [F+1][2];

  // Root setup: numerator and denominator per lane, keep roots inside (0,1)
  always_comb begin
    dn = $signed(NW'(root));
    an = NW'(carry.a);
    bn = NW'(carry.b);
    cn = NW'(carry.c);
    if (carry.mode.lin) begin
      n[0] = -cn;
      m[0] = bn;
      n[1] = '0;
      m[1] = '0;
      en   = {1'b0, carry.mode.blin};
    end else begin
      n[0] = dn - bn;
      n[1] = -bn - dn;
      m[0] = an <<< 1;
      m[1] = an <<< 1;
      en   = {2{!carry.mode.dneg}};
    end
    for (int k = 0; k < 2; k++) begin
      un[k]   = n[k][NW-1] ? $unsigned(-n[k]) : $unsigned(n[k]);
      um[k]   = m[k][NW-1] ? $unsigned(-m[k]) : $unsigned(m[k]);
      ok_c[k] = en[k] && (n[k] != '0) && (m[k] != '0)
                && (n[k][NW-1] == m[k][NW-1]) && (un[k] < um[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pq[0]  <= carry.pts;
    okq[0] <= ok_c;
    for (int k = 0; k < 2; k++) begin
      umq[0][k]  <= um[k][MUW-1:0];
      rq[0][k]   <= un[k][MUW-1:0];
      accq[0][k] <= '0;
    end
  end

  // Restoring division, one quotient bit per stage per lane
  for (genvar g = 0; g < F; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
    end

    for (genvar k = 0; k < 2; k++) begin : g_lane
      logic [MUW:0] r2, diff;
      logic         ge;

      always_comb begin
        r2   = {rq[g][k], 1'b0};
        diff = r2 - {1'b0, umq[g][k]};
        ge   = r2 >= {1'b0, umq[g][k]};
      end

      always_ff @(posedge clk) begin
        umq[g+1][k]  <= umq[g][k];
        rq[g+1][k]   <= ge ? diff[MUW-1:0] : r2[MUW-1:0];
        accq[g+1][k] <= {accq[g][k][F-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      pq[g+1]  <= pq[g];
      okq[g+1] <= okq[g];
    end
  end

  assign out_valid = vld[F];
  assign pts       = pq[F];
  assign ok        = okq[F];
  assign frac[0]   = accq[F][0];
  assign frac[1]   = accq[F][1];

endmodule
`default_nettype wire

### rtl/cbae_lerp.sv
`default_nettype none
module cbae_lerp #(
  parameter int FRAC_BITS = cbae_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  cbae_pkg::coord_t      p,
  input  cbae_pkg::coord_t      q,
  input  logic [FRAC_BITS:0]    u,
  output cbae_pkg::coord_t      val
);

  localparam int C = cbae_pkg::COORD_BITS;
  localparam int F = FRAC_BITS;

  logic signed [C:0]   delta, ext_p, sum;
  logic [C:0]          dmag;
  logic [C+F:0]        prod_q;
  logic                neg_q;
  cbae_pkg::coord_t    p_q;
  logic [C:0]          sh;

  // Multiply |q-p| by u, then truncate toward p
  always_comb begin
    delta = (C+1)'(q) - (C+1)'(p);
    dmag  = delta[C] ? $unsigned(-delta) : $unsigned(delta);
    ext_p = (C+1)'(p_q);
    sh    = prod_q[C+F:F];
    sum   = neg_q ? ext_p - $signed(sh) : ext_p + $signed(sh);
  end

  always_ff @(posedge clk) begin
    prod_q <= dmag[C-1:0] * u;
    neg_q  <= delta[C];
    p_q    <= p;
    val    <= sum[C-1:0];
  end

endmodule
`default_nettype wire

### rtl/cbae_eval.sv
`default_nettype none
module cbae_eval #(
  parameter int FRAC_BITS = cbae_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  cbae_pkg::pts_t              pts,
  input  logic [1:0]                  ok,
  input  logic [1:0][FRAC_BITS-1:0]   frac,
  output logic                        out_valid,
  output cbae_pkg::extent_out_t       extent
);

  localparam int F = FRAC_BITS;

  logic [F:0]       u_c [2];
  logic [F:0]       u_d [2][4];
  logic             vld_d [6];
  logic [1:0]       ok_d  [6];
  cbae_pkg::coord_t lo_d  [6];
  cbae_pkg::coord_t hi_d  [6];

  cbae_pkg::coord_t a0 [2];
  cbae_pkg::coord_t a1 [2];
  cbae_pkg::coord_t a2 [2];
  cbae_pkg::coord_t b0 [2];
  cbae_pkg::coord_t b1 [2];
  cbae_pkg::coord_t v  [2];
  cbae_pkg::coord_t lo_n, hi_n;
  logic             vld_o;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      u_c[k] = {1'b1, {F{1'b0}}} - {1'b0, frac[k]};
    end
  end

  // Three de Casteljau levels per lane, each level a registered lerp
  for (genvar k = 0; k < 2; k++) begin : g_lane
    cbae_lerp #(.FRAC_BITS(F)) u_a0 (.clk(clk), .p(pts.p0), .q(pts.p1), .u(u_c[k]),
                                     .val(a0[k]));
    cbae_lerp #(.FRAC_BITS(F)) u_a1 (.clk(clk), .p(pts.p1), .q(pts.p2), .u(u_c[k]),
                                     .val(a1[k]));
    cbae_lerp #(.FRAC_BITS(F)) u_a2 (.clk(clk), .p(pts.p2), .q(pts.p3), .u(u_c[k]),
                                     .val(a2[k]));
    cbae_lerp #(.FRAC_BITS(F)) u_b0 (.clk(clk), .p(a0[k]), .q(a1[k]), .u(u_d[k][1]),
                                     .val(b0[k]));
    cbae_lerp #(.FRAC_BITS(F)) u_b1 (.clk(clk), .p(a1[k]), .q(a2[k]), .u(u_d[k][1]),
                                     .val(b1[k]));
    cbae_lerp #(.FRAC_BITS(F)) u_v  (.clk(clk), .p(b0[k]), .q(b1[k]), .u(u_d[k][3]),
                                     .val(v[k]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        vld_d[i] <= 1'b0;
      end
      vld_o <= 1'b0;
    end else begin
      vld_d[0] <= in_valid;
      for (int i = 1; i < 6; i++) begin
        vld_d[i] <= vld_d[i-1];
      end
      vld_o <= vld_d[5];
    end
  end

  always_ff @(posedge clk) begin
    ok_d[0] <= ok;
    lo_d[0] <= pts.lo;
    hi_d[0] <= pts.hi;
    for (int i = 1; i < 6; i++) begin
      ok_d[i] <= ok_d[i-1];
      lo_d[i] <= lo_d[i-1];
      hi_d[i] <= hi_d[i-1];
    end
    for (int k = 0; k < 2; k++) begin
      u_d[k][0] <= u_c[k];
      for (int i = 1; i < 4; i++) begin
        u_d[k][i] <= u_d[k][i-1];
      end
    end
  end

  // Widen by each accepted root's curve value
  always_comb begin
    lo_n = lo_d[5];
    hi_n = hi_d[5];
    for (int k = 0; k < 2; k++) begin
      if (ok_d[5][k]) begin
        if (v[k] < lo_n) lo_n = v[k];
        if (v[k] > hi_n) hi_n = v[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    extent.lo_out <= lo_n;
    extent.hi_out <= hi_n;
  end

  assign out_valid = vld_o;

endmodule
`default_nettype wire
